// ===== hdl/hsvtb_pkg.sv =====
`default_nettype none
package hsvtb_pkg;

   // divider geometry: 24-bit dividend, 8-bit divisor, 4 quotient bits per stage
   localparam int DIV_NUM_W  = 24;
   localparam int DIV_DEN_W  = 8;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;
   localparam int DIV_LANES  = 3;

   // division lanes
   localparam int LANE_BASE_SAT = 0;
   localparam int LANE_TINT_SAT = 1;
   localparam int LANE_TINT_HUE = 2;

   localparam logic [19:0] HUE_SPAN = 20'd65535;
   localparam logic [7:0]  CH_MAX   = 8'd255;
   localparam logic [7:0]  OVL_MID  = 8'd127;

   // reciprocals: x/255 == (x*M255)>>31 for x < 2^24, x/127 == (x*M127)>>22 for x < 33554
   localparam logic [23:0] M255 = 24'd8421505;
   localparam logic [15:0] M127 = 16'd33027;

   localparam logic [2:0] SEC_0 = 3'd0;
   localparam logic [2:0] SEC_1 = 3'd1;
   localparam logic [2:0] SEC_2 = 3'd2;
   localparam logic [2:0] SEC_3 = 3'd3;
   localparam logic [2:0] SEC_4 = 3'd4;
   localparam logic [2:0] SEC_5 = 3'd5;

   typedef struct packed {
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] md;
      logic [2:0] sec;
   } prep_type;

   // travels alongside the divider
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] base_v;
      logic [7:0] tint_v;
      logic [2:0] tint_sec;
      logic       base_grey;
      logic       tint_grey;
   } side_type;

   function automatic prep_type prep(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
      prep_type o;
      logic [7:0] lo;
      logic [7:0] hi;
      lo = (r < g) ? r : g;
      hi = (r > g) ? r : g;
      lo = (b < lo) ? b : lo;
      hi = (b > hi) ? b : hi;
      o.hi = hi;
      o.lo = lo;
      // majority-vote median
      if ((r > g) != (r > b)) begin
         o.md = r;
      end else if ((g < r) != (g < b)) begin
         o.md = g;
      end else begin
         o.md = b;
      end
      if (hi == r && lo == b) begin
         o.sec = SEC_0;
      end else if (hi == g && lo == b) begin
         o.sec = SEC_1;
      end else if (hi == g && lo == r) begin
         o.sec = SEC_2;
      end else if (hi == b && lo == r) begin
         o.sec = SEC_3;
      end else if (hi == b && lo == g) begin
         o.sec = SEC_4;
      end else begin
         o.sec = SEC_5;
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/hsvtb_div.sv =====
`default_nettype none
// Pipelined restoring divider, several independent lanes, side data carried along.
module hsvtb_div #(
   parameter int LANES = 3,
   parameter int TAG_W = 8
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            enable,
   input  wire logic                                            in_valid,
   input  wire logic [LANES-1:0][hsvtb_pkg::DIV_NUM_W-1:0]      in_num,
   input  wire logic [LANES-1:0][hsvtb_pkg::DIV_DEN_W-1:0]      in_den,
   input  wire logic [TAG_W-1:0]                                in_tag,
   output logic                                                 out_valid,
   output logic      [LANES-1:0][hsvtb_pkg::DIV_NUM_W-1:0]      out_quo,
   output logic      [TAG_W-1:0]                                out_tag
);
   localparam int NS = hsvtb_pkg::DIV_STAGES;
   localparam int NW = hsvtb_pkg::DIV_NUM_W;
   localparam int DW = hsvtb_pkg::DIV_DEN_W;

   logic [NS-1:0]                          vld_ff;
   logic [NS-1:0][LANES-1:0][DW-1:0]       rem_ff;
   logic [NS-1:0][LANES-1:0][DW-1:0]       rem_in;
   logic [NS-1:0][LANES-1:0][NW-1:0]       work_ff;
   logic [NS-1:0][LANES-1:0][NW-1:0]       work_in;
   logic [NS-1:0][LANES-1:0][DW-1:0]       den_ff;
   logic [NS-1:0][LANES-1:0][DW-1:0]       den_in;
   logic [NS-1:0][TAG_W-1:0]               tag_ff;
   logic [NS-1:0][TAG_W-1:0]               tag_in;

   always_comb begin
      logic [DW:0]   r9;
      logic [DW-1:0] r;
      logic [NW-1:0] w;
      logic [DW-1:0] dn;
      for (int g = 0; g < NS; g++) begin
         tag_in[g] = (g == 0) ? in_tag : tag_ff[(g == 0) ? 0 : g - 1];
         for (int l = 0; l < LANES; l++) begin
            if (g == 0) begin
               r  = '0;
               w  = in_num[l];
               dn = in_den[l];
            end else begin
               r  = rem_ff[g-1][l];
               w  = work_ff[g-1][l];
               dn = den_ff[g-1][l];
            end
            for (int k = 0; k < hsvtb_pkg::DIV_STEPS; k++) begin
               r9 = {r, w[NW-1]};
               w  = {w[NW-2:0], 1'b0};
               if (r9 >= {1'b0, dn}) begin
                  r9   = r9 - {1'b0, dn};
                  w[0] = 1'b1;
               end
               r = r9[DW-1:0];
            end
            rem_in[g][l]  = r;
            work_in[g][l] = w;
            den_in[g][l]  = dn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         den_ff  <= den_in;
         tag_ff  <= tag_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_quo   = work_ff[NS-1];
   assign out_tag   = tag_ff[NS-1];

endmodule
`default_nettype wire

// ===== hdl/hsv_tint_blend.sv =====
`default_nettype none
// Pipeline from req accept to rsp_tvalid: input prep, 6 divider stages,
// 9 blend/convert stages, output register.
// Throughput: one item per cycle; the whole pipe advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Reset (synchronous, active high) clears all valid bits; data regs are not reset.
module hsv_tint_blend (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // base_red, base_green, base_blue, base_alpha, tint_red, tint_green, tint_blue
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic      [31:0] rsp_tdata
);
   localparam int NL = hsvtb_pkg::DIV_LANES;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- P0: min/max/median, dividends ----------------
   hsvtb_pkg::prep_type pb, pt;
   logic [7:0] d_b, d_t, mdlo_t;
   assign pb     = hsvtb_pkg::prep(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
   assign pt     = hsvtb_pkg::prep(req_tdata[39:32], req_tdata[47:40], req_tdata[55:48]);
   assign d_b    = pb.hi - pb.lo;
   assign d_t    = pt.hi - pt.lo;
   assign mdlo_t = pt.md - pt.lo;

   logic                                       p0_vld_ff;
   logic [NL-1:0][hsvtb_pkg::DIV_NUM_W-1:0]    p0_num_ff, p0_num_in;
   logic [NL-1:0][hsvtb_pkg::DIV_DEN_W-1:0]    p0_den_ff, p0_den_in;
   hsvtb_pkg::side_type                        p0_side_ff, p0_side_in;

   always_comb begin
      // saturation = ((d<<16)-1)/hi ; hue fraction = ((md-lo)<<16)/d
      p0_num_in[hsvtb_pkg::LANE_BASE_SAT] = {d_b, 16'd0} - 24'd1;
      p0_den_in[hsvtb_pkg::LANE_BASE_SAT] = pb.hi;
      p0_num_in[hsvtb_pkg::LANE_TINT_SAT] = {d_t, 16'd0} - 24'd1;
      p0_den_in[hsvtb_pkg::LANE_TINT_SAT] = pt.hi;
      p0_num_in[hsvtb_pkg::LANE_TINT_HUE] = {mdlo_t, 16'd0};
      p0_den_in[hsvtb_pkg::LANE_TINT_HUE] = d_t;
      p0_side_in.alpha     = req_tdata[31:24];
      p0_side_in.base_v    = pb.hi;
      p0_side_in.tint_v    = pt.hi;
      p0_side_in.tint_sec  = pt.sec;
      p0_side_in.base_grey = (d_b == 8'd0);
      p0_side_in.tint_grey = (d_t == 8'd0);
   end

   // ---------------- divider ----------------
   logic                                       dv_vld;
   logic [NL-1:0][hsvtb_pkg::DIV_NUM_W-1:0]    dv_quo;
   logic [$bits(hsvtb_pkg::side_type)-1:0]     dv_tag;
   hsvtb_pkg::side_type                        dv_side;

   hsvtb_div #(
      .LANES (NL),
      .TAG_W ($bits(hsvtb_pkg::side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (p0_vld_ff),
      .in_num    (p0_num_ff),
      .in_den    (p0_den_ff),
      .in_tag    (p0_side_ff),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_tag   (dv_tag)
   );
   assign dv_side = hsvtb_pkg::side_type'(dv_tag);

   // ---------------- P1: hue, saturation delta, overlay numerator ----------------
   logic [15:0] bs, ts, smin1, y1;
   logic [16:0] frac1;
   logic [19:0] sec20, secbase, hue20;
   logic [7:0]  bv1, tv1, inv1;

   always_comb begin
      bs    = dv_side.base_grey ? 16'd0 : dv_quo[hsvtb_pkg::LANE_BASE_SAT][15:0];
      ts    = dv_side.tint_grey ? 16'd0 : dv_quo[hsvtb_pkg::LANE_TINT_SAT][15:0];
      smin1 = (bs < ts) ? bs : ts;
      y1    = ts - smin1;
      frac1 = dv_quo[hsvtb_pkg::LANE_TINT_HUE][16:0] + 17'd1;
      sec20 = {17'd0, dv_side.tint_sec};
      secbase = (sec20 << 16) - sec20;
      if (dv_side.tint_grey) begin
         hue20 = 20'd0;
      end else if (dv_side.tint_sec[0]) begin
         // odd sector runs backward; fraction may overshoot by up to 2
         hue20 = secbase + hsvtb_pkg::HUE_SPAN - {3'd0, frac1};
      end else begin
         hue20 = secbase + {3'd0, frac1};
      end
      bv1  = dv_side.base_v;
      tv1  = dv_side.tint_v;
      inv1 = hsvtb_pkg::CH_MAX - tv1;
      if (inv1 == 8'd0) begin
         inv1 = 8'd1;
      end
   end

   logic        p1_vld_ff;
   logic [18:0] p1_h_ff;
   logic [15:0] p1_smin_ff;
   logic [22:0] p1_y127_ff;
   logic [14:0] p1_onum_ff;
   logic [7:0]  p1_ofac_ff;
   logic        p1_ohi_ff;
   logic [7:0]  p1_bv_ff;
   logic [7:0]  p1_alpha_ff;
   logic [7:0]  onum_src;
   logic        ohi1;

   assign ohi1     = (bv1 > hsvtb_pkg::OVL_MID);
   assign onum_src = ohi1 ? (hsvtb_pkg::CH_MAX - bv1) : bv1;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_h_ff     <= hue20[18:0];
         p1_smin_ff  <= smin1;
         p1_y127_ff  <= ({7'd0, y1} << 7) - {7'd0, y1};
         p1_onum_ff  <= ({7'd0, onum_src} << 8) - {7'd0, onum_src};
         p1_ofac_ff  <= ohi1 ? inv1 : tv1;
         p1_ohi_ff   <= ohi1;
         p1_bv_ff    <= bv1;
         p1_alpha_ff <= dv_side.alpha;
      end
   end

   // ---------------- P2: divide by 255 and by 127 ----------------
   logic [46:0] sq_prod;
   logic [30:0] oa_prod;
   assign sq_prod = {24'd0, p1_y127_ff} * {23'd0, hsvtb_pkg::M255};
   assign oa_prod = {16'd0, p1_onum_ff} * {15'd0, hsvtb_pkg::M127};

   logic        p2_vld_ff;
   logic [18:0] p2_h_ff;
   logic [15:0] p2_smin_ff, p2_sq_ff;
   logic [7:0]  p2_oa_ff, p2_ofac_ff, p2_bv_ff, p2_alpha_ff;
   logic        p2_ohi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_h_ff     <= p1_h_ff;
         p2_smin_ff  <= p1_smin_ff;
         p2_sq_ff    <= sq_prod[46:31];
         p2_oa_ff    <= oa_prod[29:22];
         p2_ofac_ff  <= p1_ofac_ff;
         p2_ohi_ff   <= p1_ohi_ff;
         p2_bv_ff    <= p1_bv_ff;
         p2_alpha_ff <= p1_alpha_ff;
      end
   end

   // ---------------- P3: saturation done, overlay product ----------------
   logic        p3_vld_ff;
   logic [18:0] p3_h_ff;
   logic [15:0] p3_s_ff, p3_ot_ff;
   logic [7:0]  p3_bv_ff, p3_alpha_ff;
   logic        p3_ohi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_h_ff     <= p2_h_ff;
         p3_s_ff     <= p2_smin_ff + p2_sq_ff;
         p3_ot_ff    <= {8'd0, p2_oa_ff} * {8'd0, p2_ofac_ff};
         p3_ohi_ff   <= p2_ohi_ff;
         p3_bv_ff    <= p2_bv_ff;
         p3_alpha_ff <= p2_alpha_ff;
      end
   end

   // ---------------- P4: overlay product / 255 ----------------
   logic [39:0] oq_prod;
   assign oq_prod = {24'd0, p3_ot_ff} * {16'd0, hsvtb_pkg::M255};

   logic        p4_vld_ff;
   logic [18:0] p4_h_ff;
   logic [15:0] p4_s_ff;
   logic [7:0]  p4_oq_ff, p4_bv_ff, p4_alpha_ff;
   logic        p4_ohi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_h_ff     <= p3_h_ff;
         p4_s_ff     <= p3_s_ff;
         p4_oq_ff    <= oq_prod[38:31];
         p4_ohi_ff   <= p3_ohi_ff;
         p4_bv_ff    <= p3_bv_ff;
         p4_alpha_ff <= p3_alpha_ff;
      end
   end

   // ---------------- P5: overlay value, signed step toward it ----------------
   logic [7:0] ov5, mag5;
   logic       neg5;
   always_comb begin
      // both arms already land in 0..255, clamp is a no-op
      ov5  = p4_ohi_ff ? (hsvtb_pkg::CH_MAX - p4_oq_ff) : p4_oq_ff;
      neg5 = (ov5 < p4_bv_ff);
      mag5 = neg5 ? (p4_bv_ff - ov5) : (ov5 - p4_bv_ff);
   end

   logic        p5_vld_ff;
   logic [18:0] p5_h_ff;
   logic [15:0] p5_s_ff;
   logic [14:0] p5_m127_ff;
   logic        p5_neg_ff;
   logic [7:0]  p5_bv_ff, p5_alpha_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_h_ff     <= p4_h_ff;
         p5_s_ff     <= p4_s_ff;
         p5_m127_ff  <= ({7'd0, mag5} << 7) - {7'd0, mag5};
         p5_neg_ff   <= neg5;
         p5_bv_ff    <= p4_bv_ff;
         p5_alpha_ff <= p4_alpha_ff;
      end
   end

   // ---------------- P6: step / 255 (truncates toward zero) ----------------
   logic [38:0] vq_prod;
   assign vq_prod = {24'd0, p5_m127_ff} * {15'd0, hsvtb_pkg::M255};

   logic        p6_vld_ff;
   logic [18:0] p6_h_ff;
   logic [15:0] p6_s_ff;
   logic [7:0]  p6_vq_ff, p6_bv_ff, p6_alpha_ff;
   logic        p6_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_h_ff     <= p5_h_ff;
         p6_s_ff     <= p5_s_ff;
         p6_vq_ff    <= vq_prod[38:31];
         p6_neg_ff   <= p5_neg_ff;
         p6_bv_ff    <= p5_bv_ff;
         p6_alpha_ff <= p5_alpha_ff;
      end
   end

   // ---------------- P7: value, output sector and fraction ----------------
   logic [19:0] h7, f20;
   logic [2:0]  sec7;
   logic [15:0] f7;
   always_comb begin
      h7 = {1'b0, p6_h_ff};
      if (h7 < hsvtb_pkg::HUE_SPAN) begin
         sec7 = hsvtb_pkg::SEC_0;
      end else if (h7 < 20'd2 * hsvtb_pkg::HUE_SPAN) begin
         sec7 = hsvtb_pkg::SEC_1;
      end else if (h7 < 20'd3 * hsvtb_pkg::HUE_SPAN) begin
         sec7 = hsvtb_pkg::SEC_2;
      end else if (h7 < 20'd4 * hsvtb_pkg::HUE_SPAN) begin
         sec7 = hsvtb_pkg::SEC_3;
      end else if (h7 < 20'd5 * hsvtb_pkg::HUE_SPAN) begin
         sec7 = hsvtb_pkg::SEC_4;
      end else begin
         sec7 = hsvtb_pkg::SEC_5;
      end
      f20 = h7 - ((({17'd0, sec7}) << 16) - {17'd0, sec7});
      f7  = f20[15:0];
      if (f7 == 16'd0) begin
         f7 = 16'd1;
      end
      if (sec7[0]) begin
         f7 = hsvtb_pkg::HUE_SPAN[15:0] - f7;
      end
   end

   logic        p7_vld_ff;
   logic [15:0] p7_s_ff, p7_f_ff;
   logic [7:0]  p7_v_ff, p7_alpha_ff;
   logic [2:0]  p7_sec_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_s_ff     <= p6_s_ff;
         p7_f_ff     <= f7;
         p7_sec_ff   <= sec7;
         p7_v_ff     <= p6_neg_ff ? (p6_bv_ff - p6_vq_ff) : (p6_bv_ff + p6_vq_ff);
         p7_alpha_ff <= p6_alpha_ff;
      end
   end

   // ---------------- P8: chroma span d = (s*v)>>16 + 1 ----------------
   logic [23:0] sv_prod;
   assign sv_prod = {8'd0, p7_s_ff} * {16'd0, p7_v_ff};

   logic        p8_vld_ff;
   logic [15:0] p8_f_ff;
   logic [7:0]  p8_d_ff, p8_v_ff, p8_alpha_ff;
   logic [2:0]  p8_sec_ff;
   logic        p8_grey_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p8_f_ff     <= p7_f_ff;
         p8_d_ff     <= sv_prod[23:16] + 8'd1;
         p8_v_ff     <= p7_v_ff;
         p8_sec_ff   <= p7_sec_ff;
         p8_grey_ff  <= (p7_s_ff == 16'd0) || (p7_v_ff == 8'd0);
         p8_alpha_ff <= p7_alpha_ff;
      end
   end

   // ---------------- P9: min channel and ramp product ----------------
   logic [23:0] fd_prod;
   assign fd_prod = {8'd0, p8_f_ff} * {16'd0, p8_d_ff};

   logic        p9_vld_ff;
   logic [7:0]  p9_m_ff, p9_fd_ff, p9_v_ff, p9_alpha_ff;
   logic [2:0]  p9_sec_ff;
   logic        p9_grey_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p9_m_ff     <= p8_v_ff - p8_d_ff;
         p9_fd_ff    <= fd_prod[23:16];
         p9_v_ff     <= p8_v_ff;
         p9_sec_ff   <= p8_sec_ff;
         p9_grey_ff  <= p8_grey_ff;
         p9_alpha_ff <= p8_alpha_ff;
      end
   end

   // ---------------- output register: channel select ----------------
   logic [7:0] c10, rr, rg, rb;
   always_comb begin
      c10 = p9_fd_ff + p9_m_ff;
      if (p9_grey_ff) begin
         rr = p9_v_ff;
         rg = p9_v_ff;
         rb = p9_v_ff;
      end else begin
         case (p9_sec_ff)
            hsvtb_pkg::SEC_0: begin rr = p9_v_ff; rg = c10;     rb = p9_m_ff; end
            hsvtb_pkg::SEC_1: begin rr = c10;     rg = p9_v_ff; rb = p9_m_ff; end
            hsvtb_pkg::SEC_2: begin rr = p9_m_ff; rg = p9_v_ff; rb = c10;     end
            hsvtb_pkg::SEC_3: begin rr = p9_m_ff; rg = c10;     rb = p9_v_ff; end
            hsvtb_pkg::SEC_4: begin rr = c10;     rg = p9_m_ff; rb = p9_v_ff; end
            default: begin rr = p9_v_ff; rg = p9_m_ff; rb = c10; end
         endcase
      end
   end

   logic        rsp_vld_ff;
   logic [31:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_num_ff   <= p0_num_in;
         p0_den_ff   <= p0_den_in;
         p0_side_ff  <= p0_side_in;
         rsp_data_ff <= {p9_alpha_ff, rb, rg, rr};
      end
   end

   // valid bits march with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         p5_vld_ff  <= 1'b0;
         p6_vld_ff  <= 1'b0;
         p7_vld_ff  <= 1'b0;
         p8_vld_ff  <= 1'b0;
         p9_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         p0_vld_ff  <= req_tvalid;
         p1_vld_ff  <= dv_vld;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         p4_vld_ff  <= p3_vld_ff;
         p5_vld_ff  <= p4_vld_ff;
         p6_vld_ff  <= p5_vld_ff;
         p7_vld_ff  <= p6_vld_ff;
         p8_vld_ff  <= p7_vld_ff;
         p9_vld_ff  <= p8_vld_ff;
         rsp_vld_ff <= p9_vld_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== tb/hsv_tint_checker.sv =====
`default_nettype none
module hsv_tint_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   output int               errors,
   output int               pending,
   output int               pixels_out
);

   typedef struct {
      int unsigned hue;
      int unsigned sat;
      int unsigned val;
   } hsv_triple_type;

   logic [31:0] tinted_q[$];

   function automatic int unsigned median3(int unsigned a, int unsigned b, int unsigned c);
      if ((a > b) != (a > c)) begin
         return a;
      end
      if ((b < a) != (b < c)) begin
         return b;
      end
      return c;
   endfunction

   function automatic hsv_triple_type rgb_to_hsv(int unsigned r, int unsigned g,
                                                 int unsigned b);
      hsv_triple_type o;
      int unsigned lo;
      int unsigned hi;
      int unsigned md;
      int unsigned span;
      logic [2:0] sec;
      int frac;
      lo = (r < g) ? r : g;
      hi = (r > g) ? r : g;
      lo = (b < lo) ? b : lo;
      hi = (b > hi) ? b : hi;
      md = median3(r, g, b);
      span = hi - lo;
      o.val = hi;
      o.hue = 0;
      o.sat = 0;
      if (span == 0 || hi == 0) begin
         return o;
      end
      o.sat = ((span << 16) - 1) / hi;
      if (hi == r && lo == b) begin
         sec = hsvtb_pkg::SEC_0;
      end else if (hi == g && lo == b) begin
         sec = hsvtb_pkg::SEC_1;
      end else if (hi == g && lo == r) begin
         sec = hsvtb_pkg::SEC_2;
      end else if (hi == b && lo == r) begin
         sec = hsvtb_pkg::SEC_3;
      end else if (hi == b && lo == g) begin
         sec = hsvtb_pkg::SEC_4;
      end else begin
         sec = hsvtb_pkg::SEC_5;
      end
      frac = int'(((md - lo) << 16) / span) + 1;
      if (sec[0]) begin
         frac = 65535 - frac;
      end
      o.hue = int'(65535 * int'(sec) + frac);
      return o;
   endfunction

   function automatic int clip8(int x);
      return (x < 0) ? 0 : ((x > 255) ? 255 : x);
   endfunction

   function automatic int overlay_v(int bv, int tv);
      int inv;
      if (bv > 127) begin
         inv = 255 - tv;
         if (inv < 1) begin
            inv = 1;
         end
         return clip8(255 - inv * ((255 - bv) * 255 / 127) / 255);
      end
      return clip8(tv * (bv * 255 / 127) / 255);
   endfunction

   // Tinted pixel for one request item; packed like rsp_tdata.
   function automatic logic [31:0] tint_pixel(logic [55:0] px);
      hsv_triple_type bh;
      hsv_triple_type th;
      int unsigned smin;
      int unsigned s;
      int unsigned v;
      int unsigned f;
      int unsigned dd;
      int unsigned m;
      int unsigned c;
      int ov;
      int bvi;
      logic [2:0] sec;
      logic [7:0] rr;
      logic [7:0] rg;
      logic [7:0] rb;
      bh = rgb_to_hsv(px[7:0], px[15:8], px[23:16]);
      th = rgb_to_hsv(px[39:32], px[47:40], px[55:48]);
      smin = (bh.sat < th.sat) ? bh.sat : th.sat;
      s = (smin + ((th.sat - smin) * 127) / 255) & 32'hFFFF;
      bvi = int'(bh.val);
      ov = overlay_v(bvi, int'(th.val));
      v = int'(bvi + ((ov - bvi) * 127) / 255) & 32'hFF;
      if (s == 0 || v == 0) begin
         rr = v[7:0];
         rg = v[7:0];
         rb = v[7:0];
      end else begin
         if (th.hue < 65535) sec = hsvtb_pkg::SEC_0;
         else if (th.hue < 2 * 65535) sec = hsvtb_pkg::SEC_1;
         else if (th.hue < 3 * 65535) sec = hsvtb_pkg::SEC_2;
         else if (th.hue < 4 * 65535) sec = hsvtb_pkg::SEC_3;
         else if (th.hue < 5 * 65535) sec = hsvtb_pkg::SEC_4;
         else sec = hsvtb_pkg::SEC_5;
         f = th.hue - 65535 * int'(sec);
         if (f == 0) begin
            f = 1;
         end
         if (sec[0]) begin
            f = 65535 - f;
         end
         dd = ((s * v) >> 16) + 1;
         m = (v - dd) & 32'hFF;
         c = (((f * dd) >> 16) + m) & 32'hFF;
         case (sec)
            hsvtb_pkg::SEC_0: begin rr = v[7:0]; rg = c[7:0]; rb = m[7:0]; end
            hsvtb_pkg::SEC_1: begin rr = c[7:0]; rg = v[7:0]; rb = m[7:0]; end
            hsvtb_pkg::SEC_2: begin rr = m[7:0]; rg = v[7:0]; rb = c[7:0]; end
            hsvtb_pkg::SEC_3: begin rr = m[7:0]; rg = c[7:0]; rb = v[7:0]; end
            hsvtb_pkg::SEC_4: begin rr = c[7:0]; rg = m[7:0]; rb = v[7:0]; end
            default: begin rr = v[7:0]; rg = m[7:0]; rb = c[7:0]; end
         endcase
      end
      return {px[31:24], rb, rg, rr};
   endfunction

   // Channels are driven at the rising edge, so mid-cycle values show
   // exactly what the next edge will take.
   always @(negedge clock) begin
      logic [31:0] want;
      if (reset) begin
         tinted_q.delete();
         errors = 0;
         pixels_out = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            tinted_q.push_back(tint_pixel(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            pixels_out++;
            if (tinted_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, actual %h", $time, rsp_tdata);
            end else begin
               want = tinted_q.pop_front();
               if (want !== rsp_tdata) begin
                  errors++;
                  $display("%0t: mismatch, expected %h actual %h (a,b,g,r)",
                           $time, want, rsp_tdata);
               end
            end
         end
      end
      pending = tinted_q.size();
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;

   localparam int RANDOM_PIXELS = 1250;
   localparam int CALM_TAIL     = 150;   // last items: no idling on either side
   localparam int STALL_LIMIT   = 2000;  // idle cycles before the watchdog fires

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   int  errors;
   int  pending;
   int  pixels_out;
   int  pixels_in = 0;
   bit  calm = 1'b0;
   bit  ready_mid;
   int  quiet_cycles = 0;

   always #5 clock = ~clock;

   hsv_tint_blend dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   hsv_tint_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending), .pixels_out(pixels_out)
   );

   // ready settles after the edge; the mid-cycle copy is what the next edge sees
   always @(negedge clock) begin
      ready_mid <= req_tready;
   end

   // receiver: random stall bursts, none in the calm tail
   always @(posedge clock) begin
      int stall_left;
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: cycles with no item moving on either channel
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one pixel pair; req_tvalid stays high into the next item unless that item opens with an idle gap
   task automatic push_pixel(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                             logic [7:0] ba, logic [7:0] tr, logic [7:0] tg,
                             logic [7:0] tb);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tb, tg, tr, ba, bb, bg, br};
      do @(posedge clock); while (!ready_mid);
      pixels_in++;
   endtask

   // a channel value biased toward extremes and ties
   function automatic logic [7:0] pick_channel(logic [7:0] tie);
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2, 3:    return tie;
         4:       return 8'(tie + $urandom_range(0, 2) - 1);
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      logic [7:0] t;
      logic [7:0] u;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: black, white, greys, primaries and secondaries, ties,
      // both overlay branches, saturated tint value, alpha extremes
      push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
      push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      push_pixel(8'd128, 8'd128, 8'd128, 8'h5a,  8'd255, 8'd0,   8'd0);
      push_pixel(8'd127, 8'd127, 8'd127, 8'ha5,  8'd0,   8'd255, 8'd0);
      push_pixel(8'd200, 8'd10,  8'd10,  8'd255, 8'd0,   8'd0,   8'd255);
      push_pixel(8'd10,  8'd200, 8'd10,  8'd1,   8'd255, 8'd255, 8'd0);
      push_pixel(8'd10,  8'd10,  8'd200, 8'd128, 8'd0,   8'd255, 8'd255);
      push_pixel(8'd255, 8'd0,   8'd0,   8'd7,   8'd255, 8'd0,   8'd255);
      push_pixel(8'd255, 8'd255, 8'd0,   8'd9,   8'd255, 8'd255, 8'd254);
      push_pixel(8'd0,   8'd255, 8'd255, 8'd11,  8'd1,   8'd0,   8'd0);
      push_pixel(8'd255, 8'd0,   8'd255, 8'd13,  8'd0,   8'd0,   8'd1);
      push_pixel(8'd1,   8'd0,   8'd0,   8'd15,  8'd255, 8'd254, 8'd0);
      push_pixel(8'd100, 8'd100, 8'd50,  8'd17,  8'd100, 8'd50,  8'd100);
      push_pixel(8'd50,  8'd100, 8'd100, 8'd19,  8'd50,  8'd50,  8'd100);
      push_pixel(8'd100, 8'd50,  8'd50,  8'd21,  8'd100, 8'd100, 8'd50);
      push_pixel(8'd128, 8'd0,   8'd64,  8'd23,  8'd255, 8'd128, 8'd0);
      push_pixel(8'd127, 8'd64,  8'd0,   8'd25,  8'd0,   8'd127, 8'd255);
      push_pixel(8'd255, 8'd1,   8'd2,   8'd27,  8'd2,   8'd1,   8'd255);
      push_pixel(8'd3,   8'd2,   8'd1,   8'd29,  8'd1,   8'd3,   8'd2);
      push_pixel(8'd0,   8'd0,   8'd0,   8'd31,  8'd200, 8'd100, 8'd0);

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == RANDOM_PIXELS - CALM_TAIL) begin
            calm = 1'b1;
         end
         // drain the pipe once in the middle of the run
         if (i == RANDOM_PIXELS / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         t = 8'($urandom);
         u = 8'($urandom);
         if ($urandom_range(0, 2) == 0) begin
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            push_pixel(pick_channel(t), pick_channel(t), pick_channel(t), 8'($urandom),
                       pick_channel(u), pick_channel(u), pick_channel(u));
         end
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("tinted %0d pixels (%0d checked): greys, ties, extreme channels,",
               pixels_in, pixels_out);
      $display("both overlay branches, with random stalls on both channels");
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
